@@ rtl/sha_pkg.sv @@
// Shared types, constants and round tables for the SHA-256 stream hasher.
package sha_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic {
        ACT_ABSORB = 1'b0,
        ACT_FINISH = 1'b1
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
        logic        too_long;
    } result_t;

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            default: v = 32'h5be0cd19;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/sha256_stream_hasher.sv @@
// Top level of the SHA-256 stream hasher: input queue plus hashing core.
// Absorb: each byte word is shifted into the block window; every 64th byte starts the 64 rounds.
// Finish: padding shifts in one byte a cycle up to the block end, then 64
// rounds (a second padded block when 56 or more bytes were pending), then
// eight digest words one per cycle, while the receiver does not stall, through the output register.
// aresetn (synchronous, active low) empties the queue, loads the standard
// initial hash values and clears the byte counters and overflow flag.
module sha256_stream_hasher import sha_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] action: 0 absorb, 1 finish
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] digest_word
    output logic [3:0]  m_tuser,   // [2:0] word_index, [3] too_long
    output logic        m_tlast    // on word_index 7
);
    logic    q_valid, q_ready;
    item_t   q_item;
    result_t res;

    // Queue decouples the upstream from the block compression time.
    sha_front #(.DEPTH(QDEPTH)) u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .q_valid, .q_ready, .q_item
    );

    // Core holds the 512-bit block/schedule window and the round state.
    sha_core u_core (
        .aclk, .aresetn, .q_valid, .q_ready, .q_item,
        .r_valid(m_tvalid), .r_ready(m_tready), .r_data(res)
    );

    assign m_tdata = res.digest_word;
    assign m_tuser = {res.too_long, res.word_index};
    assign m_tlast = res.last;
endmodule

@@ rtl/sha_front.sv @@
// Input side: accepts words into a small queue ahead of the hashing core.
module sha_front import sha_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    output logic       q_valid,
    input  logic       q_ready,
    output item_t      q_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;
    logic          push, pop;

    assign s_tready = (cnt_reg != CW'(DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem[rd_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= '{action: action_t'(s_tuser), data_byte: s_tdata};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end
endmodule

@@ rtl/sha_core.sv @@
// Hashing core: block assembly, padding, 64-round compression, digest output.
module sha_core import sha_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_valid,
    output logic    q_ready,
    input  item_t   q_item,
    output logic    r_valid,
    input  logic    r_ready,
    output result_t r_data
);
    typedef enum logic [1:0] {ST_IDLE, ST_PAD, ST_ROUND, ST_EMIT} state_t;

    state_t       state_reg;
    logic [511:0] win_reg;
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [5:0]   cnt_reg, rnd_reg;
    logic [60:0]  msg_reg;
    logic         ovf_reg, pad_reg, first_reg, lenblk_reg;
    logic [63:0]  len_reg;
    logic [2:0]   idx_reg;
    logic         rv_reg;
    result_t      rd_reg;

    logic [31:0] w0, t1, t2, wnew, s0w, s1w, S0a, S1e, ch, maj;
    logic [7:0]  pad_byte;
    logic        use_len;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    assign q_ready = (state_reg == ST_IDLE);
    assign r_valid = rv_reg;
    assign r_data  = rd_reg;

    always_comb begin
        w0   = win_reg[511:480];
        s0w  = ror(win_reg[479:448], 7) ^ ror(win_reg[479:448], 18) ^ (win_reg[479:448] >> 3);
        s1w  = ror(win_reg[63:32], 17) ^ ror(win_reg[63:32], 19) ^ (win_reg[63:32] >> 10);
        wnew = s1w + win_reg[223:192] + s0w + w0;
        S1e  = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + S1e + ch + round_k(rnd_reg) + w0;
        S0a  = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2   = S0a + maj;
        use_len  = lenblk_reg && (cnt_reg >= 6'd56);
        pad_byte = first_reg ? 8'h80 : (use_len ? len_reg[63:56] : 8'h00);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            rnd_reg    <= '0;
            msg_reg    <= '0;
            ovf_reg    <= 1'b0;
            pad_reg    <= 1'b0;
            first_reg  <= 1'b0;
            lenblk_reg <= 1'b0;
            idx_reg    <= '0;
            rv_reg     <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= init_h(3'(i));
            end
        end else begin
            // In ST_EMIT the output register is reloaded or held below.
            if (rv_reg && r_ready && state_reg != ST_EMIT) begin
                rv_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        if (q_item.action == ACT_ABSORB) begin
                            win_reg <= {win_reg[503:0], q_item.data_byte};
                            cnt_reg <= cnt_reg + 1'b1;
                            if (&msg_reg) begin
                                ovf_reg <= 1'b1;
                            end else begin
                                msg_reg <= msg_reg + 1'b1;
                            end
                            if (cnt_reg == 6'd63) begin
                                state_reg <= ST_ROUND;
                                rnd_reg   <= '0;
                                v_reg     <= h_reg;
                            end
                        end else begin
                            state_reg  <= ST_PAD;
                            pad_reg    <= 1'b1;
                            first_reg  <= 1'b1;
                            lenblk_reg <= (cnt_reg < 6'd56);
                            len_reg    <= {msg_reg, 3'b000};
                        end
                    end
                end
                ST_PAD: begin
                    win_reg   <= {win_reg[503:0], pad_byte};
                    first_reg <= 1'b0;
                    cnt_reg   <= cnt_reg + 1'b1;
                    if (use_len && !first_reg) begin
                        len_reg <= {len_reg[55:0], 8'h00};
                    end
                    if (cnt_reg == 6'd63) begin
                        state_reg <= ST_ROUND;
                        rnd_reg   <= '0;
                        v_reg     <= h_reg;
                    end
                end
                ST_ROUND: begin
                    win_reg <= {win_reg[479:0], wnew};
                    v_reg   <= '{t1 + t2, v_reg[0], v_reg[1], v_reg[2],
                                 v_reg[3] + t1, v_reg[4], v_reg[5], v_reg[6]};
                    rnd_reg <= rnd_reg + 1'b1;
                    if (rnd_reg == 6'd63) begin
                        h_reg[0] <= h_reg[0] + t1 + t2;
                        h_reg[1] <= h_reg[1] + v_reg[0];
                        h_reg[2] <= h_reg[2] + v_reg[1];
                        h_reg[3] <= h_reg[3] + v_reg[2];
                        h_reg[4] <= h_reg[4] + v_reg[3] + t1;
                        h_reg[5] <= h_reg[5] + v_reg[4];
                        h_reg[6] <= h_reg[6] + v_reg[5];
                        h_reg[7] <= h_reg[7] + v_reg[6];
                        if (!pad_reg) begin
                            state_reg <= ST_IDLE;
                        end else if (lenblk_reg) begin
                            state_reg <= ST_EMIT;
                            idx_reg   <= '0;
                        end else begin
                            state_reg  <= ST_PAD;
                            lenblk_reg <= 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (!rv_reg || r_ready) begin
                        rv_reg <= 1'b1;
                        rd_reg <= '{digest_word: h_reg[idx_reg], word_index: idx_reg,
                                    last: (idx_reg == 3'd7), too_long: ovf_reg};
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == 3'd7) begin
                            state_reg <= ST_IDLE;
                            cnt_reg   <= '0;
                            msg_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            pad_reg   <= 1'b0;
                            for (int i = 0; i < 8; i++) begin
                                h_reg[i] <= init_h(3'(i));
                            end
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/sha_checker.sv @@
// Port-level checks on the hasher's digest output channel.
module sha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("digest word changed while stalled");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[2:0] == 3'd7)
        else $error("tlast on a word other than index 7");

    a_notlast: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == 3'd7 |-> m_tlast)
        else $error("index 7 without tlast");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
);

@@ verif/tb_sha256_stream_hasher.sv @@
// Self-checking testbench for the SHA-256 stream hasher: directed and random messages.
module tb_sha256_stream_hasher;
    import sha_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned BYTE_CAP = (64'd1 << 61) - 64'd1;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic        s_tuser;    // [0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [31:0] digest_word
    logic [3:0]  m_tuser;    // [2:0] word_index, [3] too_long
    logic        m_tlast;

    sha256_stream_hasher dut (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Predictor state: chaining words, pending block bytes, length count.
    logic [31:0]     hash_state [8];
    logic [7:0]      blk_bytes [64];
    int              blk_fill;
    longint unsigned msg_len;
    logic            len_overflow;

    result_t digest_queue [$];
    int      error_count;
    bit      quiet_mode;
    bit      hold_request;
    int      cycle_count;

    // Message lengths at the padding edges.
    int msg_len_pick_list [2] = '{56, 64};

    // Directed rows: action and byte.
    typedef struct {
        action_t    act;
        logic [7:0] byte_val;
    } stim_row_t;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] k_const(input int r);
        logic [31:0] tab [64] = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
        return tab[r];
    endfunction

    task automatic hash_clear();
        hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                       32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        foreach (blk_bytes[i]) blk_bytes[i] = 8'h00;
        blk_fill = 0;
        msg_len = 0;
        len_overflow = 1'b0;
    endtask

    task automatic compress_pending();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        for (int t = 16; t < 64; t++) begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        v = hash_state;
        for (int t = 0; t < 64; t++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_const(t) + w[t];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endtask

    // Advance the predictor by one accepted word; finish queues eight digest words.
    task automatic predict_word(input action_t act, input logic [7:0] b);
        longint unsigned bits;
        int idx;
        result_t r;
        if (act == ACT_ABSORB) begin
            blk_bytes[blk_fill] = b;
            blk_fill++;
            if (msg_len >= BYTE_CAP) len_overflow = 1'b1;
            else msg_len++;
            if (blk_fill == 64) begin
                compress_pending();
                blk_fill = 0;
            end
        end else begin
            bits = msg_len << 3;
            idx = blk_fill;
            blk_bytes[idx++] = 8'h80;
            if (idx > 56) begin
                while (idx < 64) blk_bytes[idx++] = 8'h00;
                compress_pending();
                idx = 0;
            end
            while (idx < 56) blk_bytes[idx++] = 8'h00;
            for (int i = 0; i < 8; i++) blk_bytes[63-i] = bits[8*i +: 8];
            compress_pending();
            for (int i = 0; i < 8; i++) begin
                r.digest_word = hash_state[i];
                r.word_index = 3'(i);
                r.last = (i == 7);
                r.too_long = len_overflow;
                digest_queue.push_back(r);
            end
            hash_clear();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("MISMATCH %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    endtask

    // Offer one word, holding valid until the handshake; random idle bursts between words outside quiet mode.
    task automatic send_word(input action_t act, input logic [7:0] b);
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        predict_word(act, b);
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_request = 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Checker on accepted digest words.
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_queue.size() == 0) begin
                report_mismatch("unexpected word", m_tdata, 32'h0);
            end else begin
                want = digest_queue.pop_front();
                if (m_tdata !== want.digest_word)
                    report_mismatch("digest_word", m_tdata, want.digest_word);
                if (m_tuser[2:0] !== want.word_index)
                    report_mismatch("word_index", 32'(m_tuser[2:0]), 32'(want.word_index));
                if (m_tlast !== want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
                if (m_tuser[3] !== want.too_long)
                    report_mismatch("too_long", 32'(m_tuser[3]), 32'(want.too_long));
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_sha256_stream_hasher failed");
            $finish;
        end
    end

    initial begin
        stim_row_t rows [$];
        int msg_len_pick;
        int sent;
        error_count = 0;
        quiet_mode = 0;
        hold_request = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = ACT_ABSORB;
        hash_clear();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty message: the known digest of "" checks words 0 and 7 of the predictor.
        send_word(ACT_FINISH, 8'hff);
        if (digest_queue[0].digest_word !== 32'he3b0c442 ||
            digest_queue[7].digest_word !== 32'h7852b855)
            report_mismatch("empty digest predictor", digest_queue[0].digest_word,
                            32'he3b0c442);

        // "abc" then finish, then byte extremes then finish, then an empty message.
        rows = '{'{ACT_ABSORB, 8'h61}, '{ACT_ABSORB, 8'h62}, '{ACT_ABSORB, 8'h63},
                 '{ACT_FINISH, 8'h00},
                 '{ACT_ABSORB, 8'h00}, '{ACT_ABSORB, 8'hff}, '{ACT_ABSORB, 8'h55},
                 '{ACT_ABSORB, 8'haa}, '{ACT_FINISH, 8'hff}, '{ACT_FINISH, 8'h00}};
        foreach (rows[i]) send_word(rows[i].act, rows[i].byte_val);
        if (hash_state[0] !== 32'h6a09e667)
            report_mismatch("predictor reinit", hash_state[0], 32'h6a09e667);

        // Padding edges: 56 bytes needs a second padded block, 64 fills one first.
        foreach (msg_len_pick_list[i]) begin
            for (int j = 0; j < msg_len_pick_list[i]; j++)
                send_word(ACT_ABSORB, 8'($urandom));
            send_word(ACT_FINISH, 8'($urandom));
        end

        // Long receiver hold-off while the sender keeps pushing messages.
        hold_request = 1'b1;
        for (int j = 0; j < 3; j++) send_word(ACT_ABSORB, 8'($urandom));
        send_word(ACT_FINISH, 8'h00);
        send_word(ACT_FINISH, 8'h00);
        for (int j = 0; j < 5; j++) send_word(ACT_ABSORB, 8'($urandom));
        send_word(ACT_FINISH, 8'h00);

        // Random short messages.
        sent = 0;
        while (sent < 24) begin
            if (sent > 16) quiet_mode = 1'b1;
            msg_len_pick = $urandom_range(0, 12);
            for (int j = 0; j < msg_len_pick; j++) begin
                send_word(ACT_ABSORB, 8'($urandom));
                sent++;
            end
            send_word(ACT_FINISH, 8'($urandom));
            sent++;
        end
        s_tvalid <= 1'b0;

        // Drain: wait for every digest word, then a short settle.
        while (digest_queue.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (error_count == 0)
            $display("tb_sha256_stream_hasher passed");
        else
            $display("tb_sha256_stream_hasher failed");
        $finish;
    end

endmodule
